// ----- design/mix64_word_stream_hash_unit_defines.svh -----
// Assertion macros for the word stream hash unit
`ifndef MIX64_WORD_STREAM_HASH_UNIT_DEFINES_SVH
`define MIX64_WORD_STREAM_HASH_UNIT_DEFINES_SVH

`ifndef SYNTH
// same-cycle implication, checked out of reset
`define M64H_ASSERT_SAME(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("m64h: same-cycle check failed");
// next-cycle implication, checked out of reset
`define M64H_ASSERT_NEXT(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("m64h: next-cycle check failed");
`else
`define M64H_ASSERT_SAME(label, ante, cons)
`define M64H_ASSERT_NEXT(label, ante, cons)
`endif

`endif

// ----- design/m64h_pkg.sv -----
// Shared types, constants and helpers for the word stream hash unit
package m64h_pkg;

    localparam logic [63:0] MIX_MUL_A = 64'hBF58476D1CE4E5B9;
    localparam logic [63:0] MIX_MUL_B = 64'h94D049BB133111EB;
    localparam int unsigned MIX_SH_A = 30;
    localparam int unsigned MIX_SH_B = 27;
    localparam int unsigned MIX_SH_C = 31;

    localparam int unsigned QUEUE_DEPTH = 4;
    localparam int unsigned QPTR_W      = $clog2(QUEUE_DEPTH);

    // one classified request handed from the front to the back
    typedef struct packed {
        logic        first;
        logic        last;
        logic [63:0] seed_len;
        logic [63:0] word_mix;
    } item_t;

    typedef enum logic [2:0] {
        MIX_IDLE,
        MIX_MUL_A_ST,
        MIX_SUM_A_ST,
        MIX_MUL_B_ST,
        MIX_SUM_B_ST
    } mix_state_t;

    typedef enum logic [1:0] {
        FR_IDLE,
        FR_MIX,
        FR_HOLD
    } front_state_t;

    typedef enum logic [1:0] {
        BK_IDLE,
        BK_SEED,
        BK_FOLD,
        BK_WAIT
    } back_state_t;

    // keep the low n bytes, zero for n = 0
    function automatic logic [63:0] tail_mask(input logic [2:0] n);
        logic [63:0] m;
        m = '0;
        for (int i = 0; i < 8; i++)
        begin
            if (3'(i) < n)
            begin
                m[i*8 +: 8] = 8'hFF;
            end
        end
        return m;
    endfunction

endpackage

// ----- design/m64h_mix.sv -----
// Iterative mix64 finaliser: one shared 32-bit partial product bank, four steps
module m64h_mix
    import m64h_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        start,
    input  logic [63:0] x,
    output logic        done,
    output logic [63:0] result
);

    mix_state_t  state_reg, state_next;
    logic        done_reg, done_next;
    logic [63:0] v_reg;
    logic [63:0] pp0_reg;
    logic [31:0] pp1_reg, pp2_reg;

    logic [63:0] k;
    logic [63:0] pp0;
    logic [31:0] pp1, pp2;
    logic [63:0] sum;

    assign k   = (state_reg == MIX_MUL_A_ST) ? MIX_MUL_A : MIX_MUL_B;
    assign pp0 = 64'(v_reg[31:0]) * 64'(k[31:0]);
    assign pp1 = v_reg[63:32] * k[31:0];
    assign pp2 = v_reg[31:0] * k[63:32];
    // product mod 2^64: cross terms only reach the upper half
    assign sum = pp0_reg + {pp1_reg + pp2_reg, 32'b0};

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= MIX_IDLE;
            done_reg  <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            done_reg  <= done_next;
        end
    end

    always_ff @(posedge clk)
    begin
        unique case (state_reg)
            MIX_IDLE:
            begin
                if (start)
                begin
                    v_reg <= x ^ (x >> MIX_SH_A);
                end
            end
            MIX_MUL_A_ST, MIX_MUL_B_ST:
            begin
                pp0_reg <= pp0;
                pp1_reg <= pp1;
                pp2_reg <= pp2;
            end
            MIX_SUM_A_ST:
            begin
                v_reg <= sum ^ (sum >> MIX_SH_B);
            end
            MIX_SUM_B_ST:
            begin
                v_reg <= sum ^ (sum >> MIX_SH_C);
            end
            default:
            begin
                v_reg <= v_reg;
            end
        endcase
    end

    always_comb
    begin
        state_next = state_reg;
        done_next  = 1'b0;
        unique case (state_reg)
            MIX_IDLE:
            begin
                if (start)
                begin
                    state_next = MIX_MUL_A_ST;
                end
            end
            MIX_MUL_A_ST: state_next = MIX_SUM_A_ST;
            MIX_SUM_A_ST: state_next = MIX_MUL_B_ST;
            MIX_MUL_B_ST: state_next = MIX_SUM_B_ST;
            MIX_SUM_B_ST:
            begin
                state_next = MIX_IDLE;
                done_next  = 1'b1;
            end
            default: state_next = MIX_IDLE;
        endcase
    end

    assign done   = done_reg;
    assign result = v_reg;

endmodule

// ----- design/m64h_front.sv -----
// Front end: takes input requests, masks the tail, mixes the data word
module m64h_front
    import m64h_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        push,
    output logic        full,
    input  logic        first_word,
    input  logic [31:0] message_length,
    input  logic [63:0] data_word,
    input  logic        last_word,
    input  logic [63:0] seed,
    output logic        q_push,
    input  logic        q_full,
    output item_t       q_wdata
);

    front_state_t state_reg, state_next;
    logic [2:0]   tail_count_reg, tail_count_next;
    logic         first_reg;
    logic         last_reg;
    logic [63:0]  seed_len_reg;

    logic         accept;
    logic [2:0]   tail_eff;
    logic [63:0]  word_in;
    logic         mix_done;
    logic [63:0]  mix_result;

    m64h_mix u_mix (
        .clk    (clk),
        .rst_n  (rst_n),
        .start  (accept),
        .x      (word_in),
        .done   (mix_done),
        .result (mix_result)
    );

    // a first request sets the tail size for its own tail too
    assign tail_eff = first_word ? message_length[2:0] : tail_count_reg;
    assign word_in  = last_word ? (data_word & tail_mask(tail_eff)) : data_word;

    assign q_push = (((state_reg == FR_MIX) && mix_done) || (state_reg == FR_HOLD)) && !q_full;
    assign full   = !((state_reg == FR_IDLE) || q_push);
    assign accept = push && !full;

    assign q_wdata.first    = first_reg;
    assign q_wdata.last     = last_reg;
    assign q_wdata.seed_len = seed_len_reg;
    assign q_wdata.word_mix = mix_result;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= FR_IDLE;
            tail_count_reg <= 3'd0;
        end
        else
        begin
            state_reg      <= state_next;
            tail_count_reg <= tail_count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            first_reg    <= first_word;
            last_reg     <= last_word;
            seed_len_reg <= seed ^ {32'b0, message_length};
        end
    end

    always_comb
    begin
        state_next      = state_reg;
        tail_count_next = tail_count_reg;
        if (accept && first_word)
        begin
            tail_count_next = message_length[2:0];
        end
        unique case (state_reg)
            FR_IDLE:
            begin
                if (accept)
                begin
                    state_next = FR_MIX;
                end
            end
            FR_MIX:
            begin
                if (mix_done)
                begin
                    if (q_push)
                    begin
                        state_next = accept ? FR_MIX : FR_IDLE;
                    end
                    else
                    begin
                        state_next = FR_HOLD;
                    end
                end
            end
            FR_HOLD:
            begin
                if (q_push)
                begin
                    state_next = accept ? FR_MIX : FR_IDLE;
                end
            end
            default: state_next = FR_IDLE;
        endcase
    end

endmodule

// ----- design/m64h_fifo.sv -----
// Small request queue between front and back
module m64h_fifo
    import m64h_pkg::*;
(
    input  logic  clk,
    input  logic  rst_n,
    input  logic  push,
    input  item_t wdata,
    output logic  full,
    input  logic  pop,
    output item_t rdata,
    output logic  empty
);

    item_t              mem_reg [QUEUE_DEPTH];
    logic [QPTR_W-1:0]  wr_ptr_reg, wr_ptr_next;
    logic [QPTR_W-1:0]  rd_ptr_reg, rd_ptr_next;
    logic [QPTR_W:0]    count_reg, count_next;
    logic               do_push, do_pop;

    assign full    = (count_reg == (QPTR_W + 1)'(QUEUE_DEPTH));
    assign empty   = (count_reg == '0);
    assign do_push = push && !full;
    assign do_pop  = pop && !empty;
    assign rdata   = mem_reg[rd_ptr_reg];

    always_comb
    begin
        wr_ptr_next = do_push ? wr_ptr_reg + 1'b1 : wr_ptr_reg;
        rd_ptr_next = do_pop ? rd_ptr_reg + 1'b1 : rd_ptr_reg;
        count_next  = count_reg;
        if (do_push && !do_pop)
        begin
            count_next = count_reg + 1'b1;
        end
        else if (do_pop && !do_push)
        begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (do_push)
        begin
            mem_reg[wr_ptr_reg] <= wdata;
        end
    end

endmodule

// ----- design/m64h_back.sv -----
// Back end: folds queued requests into the running hash, holds the result
module m64h_back
    import m64h_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  item_t       q_rdata,
    input  logic        q_empty,
    output logic        q_pop,
    output logic        out_valid,
    output logic [63:0] out_hash,
    input  logic        out_pop
);

    back_state_t state_reg, state_next;
    logic [63:0] running_hash_reg, running_hash_next;
    logic        out_valid_reg, out_valid_next;
    logic [63:0] out_hash_reg;

    logic        mix_start;
    logic [63:0] mix_x;
    logic        mix_done;
    logic [63:0] mix_result;
    logic        slot_free;
    logic        out_load;

    m64h_mix u_mix (
        .clk    (clk),
        .rst_n  (rst_n),
        .start  (mix_start),
        .x      (mix_x),
        .done   (mix_done),
        .result (mix_result)
    );

    assign slot_free = !out_valid_reg || out_pop;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg        <= BK_IDLE;
            running_hash_reg <= '0;
            out_valid_reg    <= 1'b0;
        end
        else
        begin
            state_reg        <= state_next;
            running_hash_reg <= running_hash_next;
            out_valid_reg    <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (out_load)
        begin
            out_hash_reg <= mix_result;
        end
    end

    always_comb
    begin
        state_next        = state_reg;
        running_hash_next = running_hash_reg;
        mix_start         = 1'b0;
        mix_x             = running_hash_reg ^ q_rdata.word_mix;
        q_pop             = 1'b0;
        out_load          = 1'b0;
        unique case (state_reg)
            BK_IDLE:
            begin
                if (!q_empty)
                begin
                    mix_start = 1'b1;
                    if (q_rdata.first)
                    begin
                        mix_x      = q_rdata.seed_len;
                        state_next = BK_SEED;
                    end
                    else
                    begin
                        state_next = BK_FOLD;
                    end
                end
            end
            BK_SEED:
            begin
                if (mix_done)
                begin
                    running_hash_next = mix_result;
                    mix_start         = 1'b1;
                    mix_x             = mix_result ^ q_rdata.word_mix;
                    state_next        = BK_FOLD;
                end
            end
            BK_FOLD:
            begin
                if (mix_done)
                begin
                    if (!q_rdata.last)
                    begin
                        running_hash_next = mix_result;
                        q_pop             = 1'b1;
                        state_next        = BK_IDLE;
                    end
                    else if (slot_free)
                    begin
                        out_load   = 1'b1;
                        q_pop      = 1'b1;
                        state_next = BK_IDLE;
                    end
                    else
                    begin
                        state_next = BK_WAIT;
                    end
                end
            end
            BK_WAIT:
            begin
                // mix result stays put until the unit is restarted
                if (slot_free)
                begin
                    out_load   = 1'b1;
                    q_pop      = 1'b1;
                    state_next = BK_IDLE;
                end
            end
            default: state_next = BK_IDLE;
        endcase
    end

    always_comb
    begin
        out_valid_next = out_valid_reg;
        if (out_load)
        begin
            out_valid_next = 1'b1;
        end
        else if (out_pop)
        begin
            out_valid_next = 1'b0;
        end
    end

    assign out_valid = out_valid_reg;
    assign out_hash  = out_hash_reg;

endmodule

// ----- design/mix64_word_stream_hash_unit.sv -----
// Word stream hash unit: mix64-folded hash over a byte message fed as 64-bit words.
// Input queue side: present first_word, message_length, data_word and last_word with
// push; a request is taken at a clock edge with push high and full low. The first
// request of a message carries the byte length; its length mod 8 bytes sets the mask
// of the tail request (last_word): its upper bytes are zeroed, and it yields one hash.
// Result queue side: hash_value is valid while empty is low and is taken with pop.
// hash_seed is loaded with hash_seed_write; change it only while the unit is idle.
// Structure: every mix64 runs on an iterative unit (two 64-bit multiplies, each as
// 32-bit partial products then a sum). The front mixes the data word, the back
// folds it into the running hash; a four-entry queue lets them slip.
// The front takes a new request only once its previous one goes into the queue;
// the back sets the rate, with a seed mix before the word fold for a first request.
// Reset clears the seed, running hash, tail size and both queues.
// A stalled receiver holds one hash in the output register; the back then waits
// and the queue and the front fill up, after which full stays high.
`include "mix64_word_stream_hash_unit_defines.svh"

module mix64_word_stream_hash_unit
    import m64h_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        push,
    output logic        full,
    input  logic        first_word,
    input  logic [31:0] message_length,
    input  logic [63:0] data_word,
    input  logic        last_word,
    output logic        empty,
    input  logic        pop,
    output logic [63:0] hash_value,
    input  logic        hash_seed_write,
    input  logic [63:0] hash_seed
);

    logic [63:0] seed_reg;
    logic        q_push, q_full, q_pop, q_empty;
    item_t       q_wdata, q_rdata;
    logic        out_valid;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            seed_reg <= '0;
        end
        else if (hash_seed_write)
        begin
            seed_reg <= hash_seed;
        end
    end

    m64h_front u_front (
        .clk            (clk),
        .rst_n          (rst_n),
        .push           (push),
        .full           (full),
        .first_word     (first_word),
        .message_length (message_length),
        .data_word      (data_word),
        .last_word      (last_word),
        .seed           (seed_reg),
        .q_push         (q_push),
        .q_full         (q_full),
        .q_wdata        (q_wdata)
    );

    m64h_fifo u_fifo (
        .clk   (clk),
        .rst_n (rst_n),
        .push  (q_push),
        .wdata (q_wdata),
        .full  (q_full),
        .pop   (q_pop),
        .rdata (q_rdata),
        .empty (q_empty)
    );

    m64h_back u_back (
        .clk       (clk),
        .rst_n     (rst_n),
        .q_rdata   (q_rdata),
        .q_empty   (q_empty),
        .q_pop     (q_pop),
        .out_valid (out_valid),
        .out_hash  (hash_value),
        .out_pop   (pop)
    );

    assign empty = !out_valid;

    `M64H_ASSERT_SAME(a_no_push_when_full, q_push, !q_full)
    `M64H_ASSERT_SAME(a_no_pop_when_empty, q_pop, !q_empty)
    `M64H_ASSERT_NEXT(a_front_busy_after_accept, push && !full, full)
    `M64H_ASSERT_NEXT(a_tail_result_not_lost, !empty && !pop, !empty)

endmodule
